>>> design/mmlp_pkg.sv
// package with sizes, constants and register map of the linear partition block
`default_nettype none

package mmlp_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 16;

    localparam int ADDR_W   = $clog2(MAX_ITEMS);
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int LEN_W    = 16;
    localparam int VAL_W    = 26;
    localparam int LIM_W    = 30;
    localparam int HI_W     = LIM_W + 1;
    localparam int NIGHTS_W = 6;
    localparam int G_W      = 7;
    localparam int K_W      = 7;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [LIM_W-1:0]    SEARCH_TOP = LIM_W'(1000000000);
    localparam logic [NIGHTS_W-1:0] NIGHTS_MAX = NIGHTS_W'(62);
    localparam logic [K_W-1:0]      OUT_LIMIT  = K_W'(64);

    // register index taken from paddr[2]
    localparam logic REG_NIGHTS = 1'b0;

    localparam logic KIND_LIMIT = 1'b0;
    localparam logic KIND_GROUP = 1'b1;

endpackage

`default_nettype wire

>>> design/mmlp_in_if.sv
// input channel: one segment length with its last flag
`default_nettype none

interface mmlp_in_if import mmlp_pkg::*;;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] length;
    logic             last;

    modport source (output valid, output length, output last, input ready);
    modport sink   (input valid, input length, input last, output ready);
endinterface

`default_nettype wire

>>> design/mmlp_out_if.sv
// output channel: the minimal limit or one group sum
`default_nettype none

interface mmlp_out_if import mmlp_pkg::*;;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [VAL_W-1:0] value;
    logic             final_res;

    modport source (output valid, output kind, output value, output final_res, input ready);
    modport sink   (input valid, input kind, input value, input final_res, output ready);
endinterface

`default_nettype wire

>>> design/min_max_linear_partition.sv
// linear partition of a run into nights+1 groups with minimal largest sum
//
// i_in takes segment lengths, one per transaction, while the block loads a run;
// up to 1024 lengths are stored, later ones are dropped. the transaction with
// last set closes the run; i_in.ready then stays low until the last result of
// the answer has entered the output register. the block binary searches the
// limit over 0..1e9 (30 steps); each step is one greedy pass over the store
// through its single read port. o_out then gives the limit (kind 0) and
// nights+1 group sums (kind 1), the last one with final_res set. when the run
// holds fewer items than groups, zero groups lead and each item forms its own
// group. a stalled result waits in the output register and the sequencer waits
// with it. nights must be written over the apb port (byte address 0) only
// while the block is idle; the block itself does not enforce it. a value of
// 63 acts as 62. synchronous reset clears the run, the sequencer, the output
// valid and nights; the store itself is not cleared.
`default_nettype none

module min_max_linear_partition import mmlp_pkg::*; (
    input  wire                i_clk,
    input  wire                i_rst_n,
    mmlp_in_if.sink            i_in,
    mmlp_out_if.source         o_out,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_LOAD, S_MID, S_FIT, S_EM_M, S_ZERO,
        S_IT_RD, S_IT_EM, S_GR_RD, S_GR_EV, S_GR_FIN
    } t_state;

    t_state                r_state;
    logic [NIGHTS_W-1:0]   r_nights;
    logic [VALUE_BITS-1:0] r_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] r_q;
    logic [CNT_W-1:0]      r_cnt;
    logic [HI_W-1:0]       r_low;
    logic [HI_W-1:0]       r_high;
    logic [LIM_W-1:0]      r_mid;
    logic [LIM_W-1:0]      r_best;
    logic [CNT_W-1:0]      r_iss;
    logic [CNT_W-1:0]      r_proc;
    logic                  r_qv;
    logic [VAL_W-1:0]      r_s;
    logic [CNT_W-1:0]      r_cuts;
    logic                  r_fail;
    logic [CNT_W-1:0]      r_i;
    logic [VAL_W-1:0]      r_rs;
    logic [CNT_W-1:0]      r_gc;
    logic [G_W-1:0]        r_zeros;
    logic [K_W-1:0]        r_k;
    logic                  r_ovld;
    logic                  r_okind;
    logic [VAL_W-1:0]      r_oval;
    logic                  r_ofin;

    logic [G_W-1:0]    w_g;
    logic [CNT_W-1:0]  w_g11;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_in_acc;
    logic              w_cfg_wr;
    logic [HI_W:0]     w_mid_sum;
    logic [LIM_W-1:0]  w_mid;
    logic              w_le;
    logic [LIM_W-1:0]  w_a;
    logic [LIM_W-1:0]  w_fsum;
    logic [LIM_W-1:0]  w_gsum;
    logic [CNT_W-1:0]  w_left;
    logic              w_force;
    logic              w_cut;
    logic              w_free;
    logic              w_em_req;
    logic              w_em_kind;
    logic [VAL_W-1:0]  w_em_val;
    logic              w_em_fin;
    logic              w_go;
    logic              w_is_last;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_NIGHTS) ? PDATA_W'(r_nights) : '0;
    assign w_cfg_wr = psel && penable && pwrite;

    assign i_in.ready      = (r_state == S_LOAD);
    assign w_in_acc        = i_in.valid && i_in.ready;
    assign o_out.valid     = r_ovld;
    assign o_out.kind      = r_okind;
    assign o_out.value     = r_oval;
    assign o_out.final_res = r_ofin;

    assign w_g       = G_W'((r_nights > NIGHTS_MAX) ? NIGHTS_MAX : r_nights) + G_W'(1);
    assign w_g11     = CNT_W'(w_g);
    assign w_rd_addr = (r_state == S_FIT) ? r_iss[ADDR_W-1:0] : r_i[ADDR_W-1:0];
    assign w_mid_sum = (HI_W+1)'(r_low) + (HI_W+1)'(r_high);
    assign w_mid     = w_mid_sum[LIM_W:1];
    assign w_le      = $signed(r_low) <= $signed(r_high);
    assign w_a       = LIM_W'(r_q);
    assign w_fsum    = LIM_W'(r_s) + w_a;
    assign w_gsum    = LIM_W'(r_rs) + w_a;
    assign w_left    = r_cnt - r_i;
    assign w_force   = (r_gc < w_g11) && (w_left < (w_g11 - r_gc));
    assign w_cut     = w_gsum > r_best;
    assign w_free    = !r_ovld || o_out.ready;
    assign w_is_last = (r_i == (r_cnt - CNT_W'(1)));

    always_comb begin
        w_em_req  = 1'b0;
        w_em_kind = KIND_GROUP;
        w_em_val  = r_rs;
        w_em_fin  = 1'b0;
        unique case (r_state)
            S_EM_M: begin
                w_em_req  = 1'b1;
                w_em_kind = KIND_LIMIT;
                w_em_val  = r_best[VAL_W-1:0];
            end
            S_ZERO: begin
                w_em_req = 1'b1;
                w_em_val = '0;
            end
            S_IT_EM: begin
                w_em_req = 1'b1;
                w_em_val = VAL_W'(r_q);
                w_em_fin = w_is_last;
            end
            S_GR_EV: begin
                w_em_req = w_force || w_cut;
            end
            S_GR_FIN: begin
                w_em_req = 1'b1;
                w_em_fin = 1'b1;
            end
            default: begin
                w_em_req = 1'b0;
            end
        endcase
        if (r_k == (OUT_LIMIT - K_W'(1))) begin
            w_em_fin = 1'b1;
        end
    end

    assign w_go = !w_em_req || w_free;

    // single port store: write while loading, registered read while computing
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_cnt < CNT_W'(MAX_ITEMS))) begin
            r_mem[r_cnt[ADDR_W-1:0]] <= i_in.length[VALUE_BITS-1:0];
        end
        r_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_nights <= '0;
            r_cnt    <= '0;
            r_low    <= '0;
            r_high   <= HI_W'(SEARCH_TOP);
            r_best   <= '0;
            r_rs     <= '0;
            r_gc     <= '0;
            r_qv     <= 1'b0;
            r_k      <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_NIGHTS)) begin
                r_nights <= pwdata[NIGHTS_W-1:0];
            end

            if (w_em_req && w_free && (r_k < OUT_LIMIT)) begin
                r_ovld  <= 1'b1;
                r_okind <= w_em_kind;
                r_oval  <= w_em_val;
                r_ofin  <= w_em_fin;
                r_k     <= r_k + K_W'(1);
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_cnt < CNT_W'(MAX_ITEMS)) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (i_in.last) begin
                            r_low   <= '0;
                            r_high  <= HI_W'(SEARCH_TOP);
                            r_best  <= '0;
                            r_state <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    if (w_le) begin
                        r_mid   <= w_mid;
                        r_iss   <= '0;
                        r_proc  <= '0;
                        r_qv    <= 1'b0;
                        r_s     <= '0;
                        r_cuts  <= '0;
                        r_fail  <= 1'b0;
                        r_state <= S_FIT;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_EM_M;
                    end
                end
                S_FIT: begin
                    if (r_proc == r_cnt) begin
                        if (!r_fail && (r_cuts < w_g11)) begin
                            r_best <= r_mid;
                            r_high <= HI_W'(r_mid) - HI_W'(1);
                        end else begin
                            r_low <= HI_W'(r_mid) + HI_W'(1);
                        end
                        r_state <= S_MID;
                    end else begin
                        r_qv <= (r_iss < r_cnt);
                        if (r_iss < r_cnt) begin
                            r_iss <= r_iss + CNT_W'(1);
                        end
                        if (r_qv) begin
                            r_proc <= r_proc + CNT_W'(1);
                            if (w_a > r_mid) begin
                                r_fail <= 1'b1;
                            end else if (w_fsum <= r_mid) begin
                                r_s <= w_fsum[VAL_W-1:0];
                            end else begin
                                r_cuts <= r_cuts + CNT_W'(1);
                                r_s    <= VAL_W'(r_q);
                            end
                        end
                    end
                end
                S_EM_M: begin
                    if (w_free) begin
                        if (r_cnt < w_g11) begin
                            r_zeros <= G_W'(w_g11 - r_cnt);
                            r_state <= S_ZERO;
                        end else begin
                            r_rs    <= '0;
                            r_gc    <= '0;
                            r_i     <= '0;
                            r_state <= S_GR_RD;
                        end
                    end
                end
                S_ZERO: begin
                    if (w_free) begin
                        r_zeros <= r_zeros - G_W'(1);
                        if (r_zeros == G_W'(1)) begin
                            r_i     <= '0;
                            r_state <= S_IT_RD;
                        end
                    end
                end
                S_IT_RD: begin
                    r_state <= S_IT_EM;
                end
                S_IT_EM: begin
                    if (w_free) begin
                        r_i <= r_i + CNT_W'(1);
                        if (w_is_last) begin
                            r_cnt   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_IT_RD;
                        end
                    end
                end
                S_GR_RD: begin
                    r_state <= S_GR_EV;
                end
                S_GR_EV: begin
                    if (w_go) begin
                        if (w_force) begin
                            r_state <= S_IT_RD;
                        end else begin
                            if (w_cut) begin
                                r_gc <= r_gc + CNT_W'(1);
                                r_rs <= VAL_W'(r_q);
                            end else begin
                                r_rs <= w_gsum[VAL_W-1:0];
                            end
                            r_i <= r_i + CNT_W'(1);
                            r_state <= w_is_last ? S_GR_FIN : S_GR_RD;
                        end
                    end
                end
                S_GR_FIN: begin
                    if (w_free) begin
                        r_cnt   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
